// File: hdl/skb_pkg.sv
// Shared constants, types and arithmetic helpers for the spline knot to Bezier converter.
`default_nettype none
package skb_pkg;

	// Field and register widths.
	localparam int COORD_W   = 16;
	localparam int FRAC_BITS = 16;
	localparam int PARAM_W   = 22;
	localparam int CFG_IDX_W = 2;

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_KIND    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TENSION = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BIAS    = 2'd2;

	// Fixed-point constants and register reset values.
	localparam longint ONE_VAL     = 64'sd1 << FRAC_BITS;
	localparam longint HALF_VAL    = ONE_VAL / 2;
	localparam logic [PARAM_W-1:0] TENSION_RST = PARAM_W'((4 * ONE_VAL + 5) / 10);
	localparam logic [PARAM_W-1:0] BIAS_RST    = PARAM_W'(ONE_VAL);

	// Matrix builder widths.
	localparam int B2_W   = 2 * PARAM_W - FRAC_BITS;
	localparam int B3_W   = B2_W + PARAM_W - FRAC_BITS;
	localparam int DEN_W  = B3_W + 2;
	localparam int MAT_W  = DEN_W + 4;
	localparam int NUM_W  = MAT_W + FRAC_BITS + 2;
	localparam int QUO_W  = FRAC_BITS + 4;
	localparam int COEF_W = PARAM_W + 3;

	// Knot datapath widths.
	localparam int PROD_W = COEF_W + COORD_W;
	localparam int SUM_W  = PROD_W + 3;
	localparam int CF_W   = SUM_W - FRAC_BITS;
	localparam int D3_W   = CF_W + 2;
	localparam int BZ_W   = D3_W + 2;

	// Exact floor division by three through a reciprocal, valid for offsets below 2^32.
	localparam logic [31:0] DIV3_OFS   = 32'(3 * (64'd1 << (D3_W - 1)));
	localparam logic [31:0] DIV3_MAGIC = 32'hAAAA_AAAB;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       take;
		logic       mul_en;
		logic [1:0] row;
		logic       div_en;
		logic       bez_en;
		logic       out_adv;
	} skb_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic need_compute;
		logic last_pt;
	} skb_sts_t;

	// Floor of v / 3 for a signed value.
	function automatic logic signed [D3_W-1:0] div3_floor(input logic signed [D3_W-1:0] v);
		logic [31:0] u;
		logic [63:0] p;
		u = 32'(v) + DIV3_OFS;
		p = 64'(u) * 64'(DIV3_MAGIC);
		return D3_W'(p >> 33) - D3_W'(64'd1 << (D3_W - 1));
	endfunction

	// Saturate to the signed coordinate range.
	function automatic logic [COORD_W-1:0] sat_coord(input logic signed [BZ_W-1:0] v);
		logic signed [BZ_W-1:0] hi;
		logic signed [BZ_W-1:0] lo;
		hi = BZ_W'((64'sd1 <<< (COORD_W - 1)) - 1);
		lo = -hi - BZ_W'(1);
		if (v > hi) begin
			return hi[COORD_W-1:0];
		end else if (v < lo) begin
			return lo[COORD_W-1:0];
		end
		return v[COORD_W-1:0];
	endfunction

endpackage
`default_nettype wire

// File: hdl/spline_knots_to_bezier_points_core.sv
// Top level of the spline knot to cubic Bezier point converter.
//
// Knots enter on the s_axis channel, one beat each: tdata holds x then y, tuser the
// start-of-curve flag, which empties the knot window before the knot is stored.
// The first three knots of a curve fill the window and give no beats. Every later
// knot gives three Bezier points on m_axis (four for the first full window), with
// tlast on the final point of that knot.
// Processing a knot that completes a window runs four basis row products through
// one bank of eight multipliers, a drain, the thirds and the points, then the
// output beats; the next knot is taken only after the last beat. A knot that
// only fills the window needs no processing.
// When m_axis_tready is low the current point holds and no knot is taken.
// A register write rebuilds the basis matrix and holds s_axis_tready low meanwhile:
// the cardinal basis is loaded directly, the beta basis in steps (16 entries through
// a one-bit-per-cycle divider). After reset the cardinal matrix of the reset
// tension is built first and the window is empty.
`default_nettype none
module spline_knots_to_bezier_points_core (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                cfg_we,
	input  wire  [skb_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire  [skb_pkg::PARAM_W-1:0]        cfg_data,
	input  wire                                s_axis_tvalid,
	output logic                               s_axis_tready,
	input  wire  [2*skb_pkg::COORD_W-1:0]      s_axis_tdata,  // knot_x, knot_y
	input  wire                                s_axis_tuser,  // start_of_curve
	output logic                               m_axis_tvalid,
	input  wire                                m_axis_tready,
	output logic [2*skb_pkg::COORD_W-1:0]      m_axis_tdata,  // bez_x, bez_y
	output logic                               m_axis_tlast
);

	localparam int XW = skb_pkg::COORD_W;

	skb_pkg::skb_cmd_t                cmd;
	skb_pkg::skb_sts_t                sts;
	logic                             mtx_busy;
	logic [3:0][skb_pkg::COEF_W-1:0]  coef_row;
	logic [XW-1:0]                    out_x;
	logic [XW-1:0]                    out_y;

	skb_mtx u_mtx (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.row       (cmd.row),
		.coef_row  (coef_row),
		.busy      (mtx_busy)
	);

	skb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.mtx_busy  (mtx_busy),
		.sts       (sts),
		.cmd       (cmd)
	);

	skb_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.in_x     (s_axis_tdata[XW-1:0]),
		.in_y     (s_axis_tdata[2*XW-1:XW]),
		.in_start (s_axis_tuser),
		.coef_row (coef_row),
		.out_x    (out_x),
		.out_y    (out_y),
		.out_last (m_axis_tlast)
	);

	assign m_axis_tdata = {out_y, out_x};

`ifndef SYNTHESIS
	// One knot at a time: no input while points are still going out.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_axis_tready && m_axis_tvalid))
		else $error("input ready while output beats pending");

	// No knot is taken while the matrix is being rebuilt.
	a_busy_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		mtx_busy |-> !s_axis_tready)
		else $error("input ready during matrix build");

	// A run of points continues until its last beat.
	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> m_axis_tvalid)
		else $error("point run ended without last beat");
`endif

endmodule
`default_nettype wire

// File: hdl/skb_mtx.sv
// Configuration registers and basis matrix builder with a serial restoring divider.
`default_nettype none
module skb_mtx (
	input  wire                                         clk,
	input  wire                                         arst_n,
	input  wire                                         cfg_we,
	input  wire  [skb_pkg::CFG_IDX_W-1:0]               cfg_index,
	input  wire  [skb_pkg::PARAM_W-1:0]                 cfg_data,
	input  wire  [1:0]                                  row,
	output logic [3:0][skb_pkg::COEF_W-1:0]             coef_row,
	output logic                                        busy
);

	localparam int PW = skb_pkg::PARAM_W;
	localparam int FB = skb_pkg::FRAC_BITS;
	localparam int CW = skb_pkg::COEF_W;
	localparam int MW = skb_pkg::MAT_W;
	localparam int NW = skb_pkg::NUM_W;
	localparam int QW = skb_pkg::QUO_W;
	localparam int DW = skb_pkg::DEN_W;
	localparam int QCNT_W = $clog2(QW);

	localparam logic [2:0] M_IDLE  = 3'd0;
	localparam logic [2:0] M_SQ    = 3'd1;
	localparam logic [2:0] M_CU    = 3'd2;
	localparam logic [2:0] M_DEN   = 3'd3;
	localparam logic [2:0] M_LOAD  = 3'd4;
	localparam logic [2:0] M_DIV   = 3'd5;
	localparam logic [2:0] M_STORE = 3'd6;

	logic                        kind_q;
	logic [PW-1:0]               tension_q;
	logic [PW-1:0]               bias_q;
	logic                        start_q;
	logic [2:0]                  state_q;
	logic [skb_pkg::B2_W-1:0]    b2_q;
	logic [skb_pkg::B3_W-1:0]    b3_q;
	logic [DW-1:0]               den_q;
	logic [3:0]                  ent_q;
	logic [QCNT_W-1:0]           cnt_q;
	logic [NW-1:0]               rem_q;
	logic [NW-1:0]               dsh_q;
	logic [QW-1:0]               quo_q;
	logic                        neg_q;
	logic signed [CW-1:0]        coef_q [4][4];

	logic signed [MW-1:0]        mt;
	logic signed [MW-1:0]        mb;
	logic signed [MW-1:0]        mb2;
	logic signed [MW-1:0]        mb3;
	logic signed [MW-1:0]        mone;
	logic signed [MW-1:0]        m_ent;
	logic signed [NW-1:0]        nval;
	logic signed [CW-1:0]        ct;
	logic signed [CW-1:0]        cone;
	logic signed [CW-1:0]        qext;
	logic [2*PW-1:0]             sq_full;
	logic [skb_pkg::B2_W+PW-1:0] cu_full;

	// Operands widened for the raw beta entries.
	always_comb begin
		mt    = $signed(MW'(tension_q));
		mb    = $signed(MW'(bias_q));
		mb2   = $signed(MW'(b2_q));
		mb3   = $signed(MW'(b3_q));
		mone  = $signed(MW'(skb_pkg::ONE_VAL));
		ct    = $signed(CW'(tension_q));
		cone  = $signed(CW'(skb_pkg::ONE_VAL));
		sq_full = (2*PW)'(bias_q) * (2*PW)'(bias_q) + (2*PW)'(skb_pkg::HALF_VAL);
		cu_full = (skb_pkg::B2_W+PW)'(b2_q) * (skb_pkg::B2_W+PW)'(bias_q)
			+ (skb_pkg::B2_W+PW)'(skb_pkg::HALF_VAL);
	end

	// Raw beta matrix entry for the current index, row-major.
	always_comb begin
		case (ent_q)
			4'd0:    m_ent = -2 * mb3;
			4'd1:    m_ent = 2 * (mt + mb3 + mb2 + mb);
			4'd2:    m_ent = -2 * (mt + mb2 + mb + mone);
			4'd3:    m_ent = 2 * mone;
			4'd4:    m_ent = 6 * mb3;
			4'd5:    m_ent = -3 * (mt + 2 * (mb3 + mb2));
			4'd6:    m_ent = 3 * (mt + 2 * mb2);
			4'd8:    m_ent = -6 * mb3;
			4'd9:    m_ent = 6 * (mb3 - mb);
			4'd10:   m_ent = 6 * mb;
			4'd12:   m_ent = 2 * mb3;
			4'd13:   m_ent = mt + 4 * (mb2 + mb);
			4'd14:   m_ent = 2 * mone;
			default: m_ent = '0;
		endcase
		// Numerator of the rounded quotient: 2 * entry * one + den.
		nval = (NW'(m_ent) <<< (FB + 1)) + $signed(NW'(den_q));
		qext = $signed(CW'(quo_q));
	end

	// Configuration registers and build sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q    <= 1'b0;
			tension_q <= skb_pkg::TENSION_RST;
			bias_q    <= skb_pkg::BIAS_RST;
			start_q   <= 1'b1;
			state_q   <= M_IDLE;
			ent_q     <= '0;
			cnt_q     <= '0;
		end else begin
			if (start_q) begin
				start_q <= 1'b0;
				ent_q   <= '0;
				state_q <= kind_q ? M_SQ : M_IDLE;
			end else begin
				case (state_q)
					M_IDLE:  state_q <= M_IDLE;
					M_SQ:    state_q <= M_CU;
					M_CU:    state_q <= M_DEN;
					M_DEN:   state_q <= M_LOAD;
					M_LOAD: begin
						cnt_q   <= '0;
						state_q <= M_DIV;
					end
					M_DIV: begin
						cnt_q <= cnt_q + QCNT_W'(1);
						if (cnt_q == QCNT_W'(QW - 1)) begin
							state_q <= M_STORE;
						end
					end
					M_STORE: begin
						ent_q   <= ent_q + 4'd1;
						state_q <= (ent_q == 4'd15) ? M_IDLE : M_LOAD;
					end
					default: state_q <= M_IDLE;
				endcase
			end
			// A register write restarts the build from the new values.
			if (cfg_we) begin
				case (cfg_index)
					skb_pkg::REG_KIND: begin
						kind_q  <= cfg_data[0];
						start_q <= 1'b1;
					end
					skb_pkg::REG_TENSION: begin
						tension_q <= cfg_data;
						start_q   <= 1'b1;
					end
					skb_pkg::REG_BIAS: begin
						bias_q  <= cfg_data;
						start_q <= 1'b1;
					end
					default: ;
				endcase
			end
		end
	end

	// Matrix arithmetic and coefficient storage; a restart drops any build in progress.
	always_ff @(posedge clk) begin
		if (start_q) begin
			if (!kind_q) begin
				coef_q[0][0] <= -ct;
				coef_q[0][1] <= CW'(2) * cone - ct;
				coef_q[0][2] <= ct - CW'(2) * cone;
				coef_q[0][3] <= ct;
				coef_q[1][0] <= CW'(2) * ct;
				coef_q[1][1] <= ct - CW'(3) * cone;
				coef_q[1][2] <= CW'(3) * cone - CW'(2) * ct;
				coef_q[1][3] <= -ct;
				coef_q[2][0] <= -ct;
				coef_q[2][1] <= '0;
				coef_q[2][2] <= ct;
				coef_q[2][3] <= '0;
				coef_q[3][0] <= '0;
				coef_q[3][1] <= cone;
				coef_q[3][2] <= '0;
				coef_q[3][3] <= '0;
			end
		end else begin
			case (state_q)
				M_SQ: b2_q <= skb_pkg::B2_W'(sq_full >> FB);
				M_CU: b3_q <= skb_pkg::B3_W'(cu_full >> FB);
				M_DEN: begin
					den_q <= DW'(tension_q) + {b3_q, 1'b0} + (DW'(b2_q) << 2)
						+ (DW'(bias_q) << 2) + DW'(2 * skb_pkg::ONE_VAL);
				end
				M_LOAD: begin
					neg_q <= nval[NW-1];
					rem_q <= nval[NW-1] ? NW'(-nval) : NW'(nval);
					dsh_q <= NW'({den_q, 1'b0}) << (QW - 1);
					quo_q <= '0;
				end
				M_DIV: begin
					if (rem_q >= dsh_q) begin
						rem_q <= rem_q - dsh_q;
						quo_q <= {quo_q[QW-2:0], 1'b1};
					end else begin
						quo_q <= {quo_q[QW-2:0], 1'b0};
					end
					dsh_q <= dsh_q >> 1;
				end
				M_STORE: begin
					// Floor division of a negative numerator rounds away from zero.
					if (!neg_q) begin
						coef_q[ent_q[3:2]][ent_q[1:0]] <= qext;
					end else if (rem_q != '0) begin
						coef_q[ent_q[3:2]][ent_q[1:0]] <= -qext - CW'(1);
					end else begin
						coef_q[ent_q[3:2]][ent_q[1:0]] <= -qext;
					end
				end
				default: ;
			endcase
		end
	end

	// Row read for the knot datapath.
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			coef_row[i] = coef_q[row][i];
		end
		busy = start_q || (state_q != M_IDLE);
	end

endmodule
`default_nettype wire

// File: hdl/skb_ctrl.sv
// Controller state machine that sequences one knot through the datapath.
`default_nettype none
module skb_ctrl (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  wire                out_ready,
	input  wire                mtx_busy,
	input  skb_pkg::skb_sts_t  sts,
	output skb_pkg::skb_cmd_t  cmd
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_SUMW = 3'd2;
	localparam logic [2:0] ST_DIV3 = 3'd3;
	localparam logic [2:0] ST_BEZ  = 3'd4;
	localparam logic [2:0] ST_OUT  = 3'd5;

	logic [2:0] state_q;
	logic [1:0] row_q;

	// Handshakes and datapath commands.
	always_comb begin
		in_ready    = (state_q == ST_IDLE) && !mtx_busy;
		out_valid   = (state_q == ST_OUT);
		cmd.take    = in_valid && in_ready;
		cmd.mul_en  = (state_q == ST_MUL);
		cmd.row     = row_q;
		cmd.div_en  = (state_q == ST_DIV3);
		cmd.bez_en  = (state_q == ST_BEZ);
		cmd.out_adv = out_valid && out_ready;
	end

	// State sequence: four row products, drain, thirds, points, beats out.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			row_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					row_q <= '0;
					if (cmd.take && sts.need_compute) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					row_q <= row_q + 2'd1;
					if (row_q == 2'd3) begin
						state_q <= ST_SUMW;
					end
				end
				ST_SUMW: state_q <= ST_DIV3;
				ST_DIV3: state_q <= ST_BEZ;
				ST_BEZ:  state_q <= ST_OUT;
				ST_OUT: begin
					if (cmd.out_adv && sts.last_pt) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// File: hdl/skb_dp.sv
// Knot window, basis multiply, Bezier conversion and output point buffer.
`default_nettype none
module skb_dp (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  skb_pkg::skb_cmd_t                   cmd,
	output skb_pkg::skb_sts_t                   sts,
	input  wire  [skb_pkg::COORD_W-1:0]         in_x,
	input  wire  [skb_pkg::COORD_W-1:0]         in_y,
	input  wire                                 in_start,
	input  wire  [3:0][skb_pkg::COEF_W-1:0]     coef_row,
	output logic [skb_pkg::COORD_W-1:0]         out_x,
	output logic [skb_pkg::COORD_W-1:0]         out_y,
	output logic                                out_last
);

	localparam int XW = skb_pkg::COORD_W;
	localparam int PW = skb_pkg::PROD_W;
	localparam int SW = skb_pkg::SUM_W;
	localparam int CF = skb_pkg::CF_W;
	localparam int DW = skb_pkg::D3_W;
	localparam int BW = skb_pkg::BZ_W;

	logic signed [XW-1:0] win_x_q [3];
	logic signed [XW-1:0] win_y_q [3];
	logic [1:0]           held_q;
	logic                 first_done_q;
	logic signed [XW-1:0] kx_q;
	logic signed [XW-1:0] ky_q;
	logic signed [PW-1:0] prod_x_s1 [4];
	logic signed [PW-1:0] prod_y_s1 [4];
	logic [1:0]           row_s1;
	logic                 vld_s1;
	logic signed [CF-1:0] c_x_q [4];
	logic signed [CF-1:0] c_y_q [4];
	logic signed [DW-1:0] d1_x_q;
	logic signed [DW-1:0] d2_x_q;
	logic signed [DW-1:0] d1_y_q;
	logic signed [DW-1:0] d2_y_q;
	logic [XW-1:0]        pts_x_q [4];
	logic [XW-1:0]        pts_y_q [4];
	logic [1:0]           out_idx_q;

	logic [1:0]           held_eff;
	logic signed [XW-1:0] kn_x [4];
	logic signed [XW-1:0] kn_y [4];
	logic signed [SW-1:0] sum_x;
	logic signed [SW-1:0] sum_y;
	logic signed [BW-1:0] bz_x [4];
	logic signed [BW-1:0] bz_y [4];

	// Window occupancy after an optional start flag, and the four knots in use.
	always_comb begin
		held_eff = in_start ? 2'd0 : held_q;
		sts.need_compute = (held_eff == 2'd3);
		sts.last_pt = (out_idx_q == 2'd3);
		for (int i = 0; i < 3; i++) begin
			kn_x[i] = win_x_q[i];
			kn_y[i] = win_y_q[i];
		end
		kn_x[3] = kx_q;
		kn_y[3] = ky_q;
	end

	// Row sums of the registered products, rounded to integers.
	always_comb begin
		sum_x = SW'(skb_pkg::HALF_VAL);
		sum_y = SW'(skb_pkg::HALF_VAL);
		for (int i = 0; i < 4; i++) begin
			sum_x = sum_x + SW'(prod_x_s1[i]);
			sum_y = sum_y + SW'(prod_y_s1[i]);
		end
	end

	// Bezier points from the cubic coefficients and the thirds.
	always_comb begin
		bz_x[0] = BW'(c_x_q[0]);
		bz_x[1] = BW'(c_x_q[0]) + BW'(d1_x_q);
		bz_x[2] = bz_x[1] + BW'(d2_x_q);
		bz_x[3] = BW'(c_x_q[0]) + BW'(c_x_q[1]) + BW'(c_x_q[2]) + BW'(c_x_q[3]);
		bz_y[0] = BW'(c_y_q[0]);
		bz_y[1] = BW'(c_y_q[0]) + BW'(d1_y_q);
		bz_y[2] = bz_y[1] + BW'(d2_y_q);
		bz_y[3] = BW'(c_y_q[0]) + BW'(c_y_q[1]) + BW'(c_y_q[2]) + BW'(c_y_q[3]);
	end

	// Control state: window fill count, first-window flag, product valid, beat index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q       <= '0;
			first_done_q <= 1'b0;
			vld_s1       <= 1'b0;
			out_idx_q    <= '0;
		end else begin
			vld_s1 <= cmd.mul_en;
			if (cmd.take) begin
				if (held_eff != 2'd3) begin
					held_q <= held_eff + 2'd1;
				end
				if (in_start) begin
					first_done_q <= 1'b0;
				end
			end
			if (cmd.bez_en) begin
				out_idx_q    <= first_done_q ? 2'd1 : 2'd0;
				first_done_q <= 1'b1;
			end else if (cmd.out_adv) begin
				out_idx_q <= out_idx_q + 2'd1;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		// Store a knot into the window or hold it as the fourth knot.
		if (cmd.take) begin
			if (held_eff != 2'd3) begin
				win_x_q[held_eff] <= $signed(in_x);
				win_y_q[held_eff] <= $signed(in_y);
			end else begin
				kx_q <= $signed(in_x);
				ky_q <= $signed(in_y);
			end
		end
		// Products of one basis row with the four knots.
		if (cmd.mul_en) begin
			row_s1 <= cmd.row;
			for (int i = 0; i < 4; i++) begin
				prod_x_s1[i] <= PW'($signed(coef_row[i])) * PW'(kn_x[i]);
				prod_y_s1[i] <= PW'($signed(coef_row[i])) * PW'(kn_y[i]);
			end
		end
		// Row r gives coefficient 3 - r.
		if (vld_s1) begin
			c_x_q[2'd3 - row_s1] <= CF'(sum_x >>> skb_pkg::FRAC_BITS);
			c_y_q[2'd3 - row_s1] <= CF'(sum_y >>> skb_pkg::FRAC_BITS);
		end
		// Rounded thirds.
		if (cmd.div_en) begin
			d1_x_q <= skb_pkg::div3_floor(DW'(c_x_q[1]) + DW'(1));
			d2_x_q <= skb_pkg::div3_floor(DW'(c_x_q[1]) + DW'(c_x_q[2]) + DW'(1));
			d1_y_q <= skb_pkg::div3_floor(DW'(c_y_q[1]) + DW'(1));
			d2_y_q <= skb_pkg::div3_floor(DW'(c_y_q[1]) + DW'(c_y_q[2]) + DW'(1));
		end
		// Saturated points, and the window slides by one knot.
		if (cmd.bez_en) begin
			for (int i = 0; i < 4; i++) begin
				pts_x_q[i] <= skb_pkg::sat_coord(bz_x[i]);
				pts_y_q[i] <= skb_pkg::sat_coord(bz_y[i]);
			end
			win_x_q[0] <= win_x_q[1];
			win_x_q[1] <= win_x_q[2];
			win_x_q[2] <= kx_q;
			win_y_q[0] <= win_y_q[1];
			win_y_q[1] <= win_y_q[2];
			win_y_q[2] <= ky_q;
		end
	end

	// Output beat.
	always_comb begin
		out_x    = pts_x_q[out_idx_q];
		out_y    = pts_y_q[out_idx_q];
		out_last = (out_idx_q == 2'd3);
	end

endmodule
`default_nettype wire

// File: bench/spline_knots_to_bezier_points_core_tb.sv
// Self-checking testbench for the spline knot to Bezier point converter.
`timescale 1ns / 100ps
`default_nettype none

// Expected Bezier point with its run marker.
typedef struct {
	logic signed [skb_pkg::COORD_W-1:0] px;
	logic signed [skb_pkg::COORD_W-1:0] py;
	logic                               last;
} bez_point_t;

// Mirrors the block's state and configuration and checks every output beat.
class bezier_scoreboard;
	logic                          kind;
	logic [skb_pkg::PARAM_W-1:0]   tension;
	logic [skb_pkg::PARAM_W-1:0]   bias;
	longint                        basis[4][4];
	longint                        win_x[3];
	longint                        win_y[3];
	int                            held;
	bit                            first_done;
	bez_point_t                    pending[$];
	int                            errors;
	int                            points_seen;

	function new();
		kind        = 1'b0;
		tension     = skb_pkg::TENSION_RST;
		bias        = skb_pkg::BIAS_RST;
		held        = 0;
		first_done  = 0;
		errors      = 0;
		points_seen = 0;
		foreach (win_x[i]) begin
			win_x[i] = 0;
			win_y[i] = 0;
		end
		rebuild_basis();
	endfunction

	static function longint floor_div(longint a, longint b);
		longint q;
		q = a / b;
		if ((a % b) != 0 && a < 0) begin
			q--;
		end
		return q;
	endfunction

	static function logic signed [skb_pkg::COORD_W-1:0] clamp(longint v);
		if (v > 32767) begin
			return 16'sh7fff;
		end else if (v < -32768) begin
			return 16'sh8000;
		end
		return v[skb_pkg::COORD_W-1:0];
	endfunction

	// Cardinal or normalized beta basis from the current registers.
	function void rebuild_basis();
		longint one, half, t, b, b2, b3, den;
		longint m[4][4];
		one  = skb_pkg::ONE_VAL;
		half = skb_pkg::HALF_VAL;
		t    = longint'(tension);
		if (kind == 1'b0) begin
			m = '{'{-t, 2*one - t, t - 2*one, t},
				'{2*t, t - 3*one, 3*one - 2*t, -t},
				'{-t, 0, t, 0},
				'{0, one, 0, 0}};
			basis = m;
		end else begin
			b   = longint'(bias);
			b2  = (b * b + half) >>> skb_pkg::FRAC_BITS;
			b3  = (b2 * b + half) >>> skb_pkg::FRAC_BITS;
			den = t + 2*b3 + 4*(b2 + b) + 2*one;
			m = '{'{-2*b3, 2*(t + b3 + b2 + b), -2*(t + b2 + b + one), 2*one},
				'{6*b3, -3*(t + 2*(b3 + b2)), 3*(t + 2*b2), 0},
				'{-6*b3, 6*(b3 - b), 6*b, 0},
				'{2*b3, t + 4*(b2 + b), 2*one, 0}};
			for (int r = 0; r < 4; r++) begin
				for (int c = 0; c < 4; c++) begin
					basis[r][c] = floor_div(2 * m[r][c] * one + den, 2 * den);
				end
			end
		end
	endfunction

	function void write_reg(logic [skb_pkg::CFG_IDX_W-1:0] idx,
			logic [skb_pkg::PARAM_W-1:0] val);
		case (idx)
			skb_pkg::REG_KIND: begin
				kind = val[0];
			end
			skb_pkg::REG_TENSION: begin
				tension = val;
			end
			skb_pkg::REG_BIAS: begin
				bias = val;
			end
			default: begin
				return;
			end
		endcase
		rebuild_basis();
	endfunction

	// Accepted knot: update the window and queue the points it causes.
	function void note_knot(logic signed [skb_pkg::COORD_W-1:0] kx,
			logic signed [skb_pkg::COORD_W-1:0] ky, logic start);
		longint kxs[4], kys[4], cx[4], cy[4], bx[4], by[4], sx, sy;
		bez_point_t pt;
		if (start) begin
			held       = 0;
			first_done = 0;
		end
		if (held < 3) begin
			win_x[held] = kx;
			win_y[held] = ky;
			held++;
			return;
		end
		for (int i = 0; i < 3; i++) begin
			kxs[i] = win_x[i];
			kys[i] = win_y[i];
		end
		kxs[3] = kx;
		kys[3] = ky;
		for (int r = 0; r < 4; r++) begin
			sx = 0;
			sy = 0;
			for (int i = 0; i < 4; i++) begin
				sx += basis[r][i] * kxs[i];
				sy += basis[r][i] * kys[i];
			end
			cx[3-r] = floor_div(sx + skb_pkg::HALF_VAL, skb_pkg::ONE_VAL);
			cy[3-r] = floor_div(sy + skb_pkg::HALF_VAL, skb_pkg::ONE_VAL);
		end
		bx[0] = cx[0];
		bx[1] = cx[0] + floor_div(cx[1] + 1, 3);
		bx[2] = bx[1] + floor_div(cx[1] + cx[2] + 1, 3);
		bx[3] = cx[0] + cx[1] + cx[2] + cx[3];
		by[0] = cy[0];
		by[1] = cy[0] + floor_div(cy[1] + 1, 3);
		by[2] = by[1] + floor_div(cy[1] + cy[2] + 1, 3);
		by[3] = cy[0] + cy[1] + cy[2] + cy[3];
		for (int i = first_done ? 1 : 0; i < 4; i++) begin
			pt.px   = clamp(bx[i]);
			pt.py   = clamp(by[i]);
			pt.last = (i == 3);
			pending.push_back(pt);
		end
		for (int i = 0; i < 3; i++) begin
			win_x[i] = kxs[i+1];
			win_y[i] = kys[i+1];
		end
		first_done = 1;
	endfunction

	// Accepted output beat against the oldest expected point.
	function void check_point(logic [2*skb_pkg::COORD_W-1:0] data, logic last);
		bez_point_t pt;
		points_seen++;
		if (pending.size() == 0) begin
			$error("unexpected point x=%0d y=%0d last=%0b", $signed(data[15:0]),
				$signed(data[31:16]), last);
			errors++;
			return;
		end
		pt = pending.pop_front();
		if (data[15:0] !== pt.px) begin
			$error("bez_x expected %0d actual %0d", pt.px, $signed(data[15:0]));
			errors++;
		end
		if (data[31:16] !== pt.py) begin
			$error("bez_y expected %0d actual %0d", pt.py, $signed(data[31:16]));
			errors++;
		end
		if (last !== pt.last) begin
			$error("last_of_run expected %0b actual %0b", pt.last, last);
			errors++;
		end
	endfunction
endclass

module spline_knots_to_bezier_points_core_tb;
	localparam logic [skb_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 400;
	localparam int CW = skb_pkg::COORD_W;
	localparam int PW = skb_pkg::PARAM_W;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            cfg_we = 1'b0;
	logic [skb_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
	logic [PW-1:0]                   cfg_data = '0;
	logic                            s_axis_tvalid = 1'b0;
	logic                            s_axis_tready;
	logic [2*CW-1:0]                 s_axis_tdata = '0;  // knot_x, knot_y
	logic                            s_axis_tuser = 1'b0;  // start_of_curve
	logic                            m_axis_tvalid;
	logic                            m_axis_tready = 1'b0;
	logic [2*CW-1:0]                 m_axis_tdata;  // bez_x, bez_y
	logic                            m_axis_tlast;

	bezier_scoreboard sb = new();
	bit     no_idle;
	bit     hold_req;
	int     knots_sent;
	int     cycles;

	spline_knots_to_bezier_points_core u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
	);

	always #5 clk = ~clk;

	// Watchdog on total run length.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Offers one knot beat after a random gap and waits for its acceptance.
	task automatic send_knot(logic signed [CW-1:0] kx, logic signed [CW-1:0] ky,
			logic start);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {ky, kx};
		s_axis_tuser  <= start;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_knot(kx, ky, start);
		knots_sent++;
	endtask

	// Waits until every expected point is out and the block has settled.
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	// One register write beat, then cfg_we drops before the next.
	task automatic write_reg(logic [skb_pkg::CFG_IDX_W-1:0] idx, logic [PW-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we    <= 1'b0;
		sb.write_reg(idx, val);
		@(posedge clk);
	endtask

	// Well-formed curves with random knots, plus some stray start flags.
	task automatic random_curves(int count);
		int n, len;
		n = 0;
		while (n < count) begin
			len = $urandom_range(4, 12);
			no_idle = ($urandom_range(0, 3) == 0);
			for (int i = 0; i < len && n < count; i++) begin
				send_knot(CW'($urandom), CW'($urandom),
					(i == 0) || ($urandom_range(0, 19) == 0));
				n++;
			end
		end
		no_idle = 0;
	endtask

	// Receiver: random stalls, and one long hold-off on request.
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				hold_req = 0;
				stall = HOLD_CYCLES;
			end else begin
				stall = no_idle ? 0 : $urandom_range(0, 13);
			end
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			sb.check_point(m_axis_tdata, m_axis_tlast);
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed knots on the reset basis: extremes, restarts mid-window.
		send_knot(16'sh0000, 16'sh0000, 1'b1);
		send_knot(16'sh7fff, 16'sh8000, 1'b0);
		send_knot(16'sh8000, 16'sh7fff, 1'b1);
		send_knot(16'sh7fff, 16'sh7fff, 1'b0);
		send_knot(16'sh8000, 16'sh8000, 1'b0);
		send_knot(16'sh7fff, 16'sh8000, 1'b0);
		send_knot(16'sh8000, 16'sh7fff, 1'b0);
		send_knot(16'shffff, 16'sh0001, 1'b0);
		send_knot(16'sh5555, 16'shaaaa, 1'b1);
		send_knot(16'sh0001, 16'shffff, 1'b0);
		send_knot(16'sh0000, 16'sh0000, 1'b0);
		send_knot(16'sh1234, 16'shedcb, 1'b0);
		send_knot(16'shaaaa, 16'sh5555, 1'b0);
		wait_drained();

		// Extreme cardinal tension, with a long receiver hold-off.
		write_reg(skb_pkg::REG_TENSION, '1);
		hold_req = 1;
		random_curves(15);
		wait_drained();

		write_reg(skb_pkg::REG_TENSION, '0);
		write_reg(REG_UNUSED, '1);
		random_curves(15);
		wait_drained();

		// Beta basis at default bias, then both extremes.
		write_reg(skb_pkg::REG_KIND, PW'(1));
		write_reg(skb_pkg::REG_TENSION, skb_pkg::TENSION_RST);
		random_curves(15);
		wait_drained();

		write_reg(skb_pkg::REG_BIAS, '0);
		random_curves(15);
		wait_drained();

		write_reg(skb_pkg::REG_BIAS, '1);
		write_reg(skb_pkg::REG_TENSION, '1);
		random_curves(15);
		wait_drained();

		write_reg(skb_pkg::REG_BIAS, PW'($urandom_range(0, 4 * 65536)));
		write_reg(skb_pkg::REG_TENSION, PW'($urandom_range(0, 4 * 65536)));
		random_curves(15);
		wait_drained();

		write_reg(skb_pkg::REG_KIND, PW'(0));
		random_curves(12);
		wait_drained();

		$display("Sent %0d knots over cardinal and beta bases at extreme settings.", knots_sent);
		$display("Checked %0d Bezier points, %0d mismatches.", sb.points_seen, sb.errors);
		if (sb.errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end
endmodule

`default_nettype wire
